// ===== hdl/fprti_pkg.sv =====
`default_nettype none
package fprti_pkg;
	typedef enum logic [1:0] {
		FN_TRUNC = 2'd0,
		FN_FLOOR = 2'd1,
		FN_CEIL  = 2'd2,
		FN_ROUND = 2'd3
	} func_t;

	localparam int unsigned DBL_MBITS = 52;
	localparam int unsigned DBL_EBITS = 11;
	localparam int unsigned SGL_MBITS = 23;
	localparam int unsigned SGL_EBITS = 8;
	localparam logic [10:0] DBL_BIAS = 11'd1023;
	localparam logic [10:0] DBL_EMAX = 11'h7ff;
	localparam logic [7:0]  SGL_BIAS = 8'd127;
	localparam logic [7:0]  SGL_EMAX = 8'hff;

	// input item as held in the input stage
	typedef struct packed {
		logic [63:0] operand;
		logic        is_single;
		func_t       func;
	} item_t;
endpackage
`default_nettype wire

// ===== hdl/fprti_core.sv =====
`default_nettype none
module fprti_core (
	input  wire fprti_pkg::item_t item,
	output logic [63:0]           result
);
	logic        sgl;
	logic [63:0] bits;
	logic        neg;
	logic [10:0] ef;
	logic [10:0] emax;
	logic [10:0] bias;
	logic [5:0]  mbits;
	logic [63:0] mag;
	logic [11:0] ediff;
	logic [63:0] unit;
	logic [63:0] mask;
	logic [63:0] frac;
	logic [63:0] trunc_v;
	logic [63:0] signbit;
	logic        up;
	logic [63:0] res;

	always_comb begin
		sgl   = item.is_single;
		bits  = sgl ? {32'd0, item.operand[31:0]} : item.operand;
		neg   = sgl ? bits[31] : bits[63];
		ef    = sgl ? {3'd0, bits[30:23]} : bits[62:52];
		emax  = sgl ? {3'd0, fprti_pkg::SGL_EMAX} : fprti_pkg::DBL_EMAX;
		bias  = sgl ? {3'd0, fprti_pkg::SGL_BIAS} : fprti_pkg::DBL_BIAS;
		mbits = sgl ? 6'(fprti_pkg::SGL_MBITS) : 6'(fprti_pkg::DBL_MBITS);
		signbit = sgl ? 64'h0000_0000_8000_0000 : 64'h8000_0000_0000_0000;
		mag   = bits & ~signbit;
		ediff = {1'b0, ef} - {1'b0, bias};
		unit  = 64'd1 << (mbits - ediff[5:0]);
		mask  = unit - 64'd1;
		frac  = bits & mask;
		trunc_v = bits & ~mask;
		up = 1'b0;
		res = bits;
		if (ef == emax) begin
			res = bits;
		end else if (ef < bias) begin
			// below one: signed zero or +/-1.0
			case (item.func)
				fprti_pkg::FN_FLOOR: up = neg;
				fprti_pkg::FN_CEIL:  up = !neg;
				fprti_pkg::FN_ROUND: up = (ef == bias - 11'd1);
				default:             up = 1'b0;
			endcase
			if (mag == 64'd0)
				res = bits;
			else
				res = (neg ? signbit : 64'd0) | (up ? ({53'd0, bias} << mbits) : 64'd0);
		end else if (ediff[10:0] >= {5'd0, mbits}) begin
			res = bits;
		end else if (frac == 64'd0) begin
			res = bits;
		end else begin
			case (item.func)
				fprti_pkg::FN_FLOOR: up = neg;
				fprti_pkg::FN_CEIL:  up = !neg;
				fprti_pkg::FN_ROUND: up = (frac >= (unit >> 1));
				default:             up = 1'b0;
			endcase
			// carry out of the significand moves into the exponent
			res = up ? trunc_v + unit : trunc_v;
		end
		result = sgl ? {32'd0, res[31:0]} : res;
	end
endmodule
`default_nettype wire

// ===== hdl/fp_round_to_integral_top.sv =====
`default_nettype none
// IEEE-754 round-to-integral unit, double or single precision. Each item
// carries an operation (truncate, floor, ceiling, round half away from zero),
// a precision flag and the operand bit pattern; the result is the integral
// value in the same format. NaN and infinity pass unchanged (payload kept,
// no quieting); magnitudes below one keep their sign. Single precision uses
// the low 32 bits and returns zeros above them. One item is accepted every
// cycle while the skid stage is empty; the path is an input register, the
// rounding logic, and an output register with a skid stage so input stays
// open while a result waits downstream.
module fp_round_to_integral_top (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [71:0] s_tdata,  // func[1:0], is_single[2], operand[66:3], zeros
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [63:0] m_tdata   // result[63:0]
);
	fprti_pkg::item_t item_s1;
	logic             vld_s1;
	logic [63:0]      res_comb;
	logic [63:0]      out_q;
	logic             out_vld_q;
	logic [63:0]      skid_q;
	logic             skid_vld_q;
	logic             adv_s1;
	logic             out_free;

	fprti_core u_core (.item(item_s1), .result(res_comb));

	// room exists while the skid slot is empty
	assign s_tready = !skid_vld_q;
	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_q;
	assign out_free = !out_vld_q || m_tready;
	// s1 holds only while both the output and the skid slot are taken
	assign adv_s1   = vld_s1 && (out_free || !skid_vld_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1     <= 1'b0;
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else begin
			if (s_tvalid && s_tready)
				vld_s1 <= 1'b1;
			else if (adv_s1)
				vld_s1 <= 1'b0;
			if (out_free) begin
				if (skid_vld_q) begin
					out_vld_q  <= 1'b1;
					skid_vld_q <= vld_s1;
				end else begin
					out_vld_q <= vld_s1;
				end
			end else if (!skid_vld_q) begin
				skid_vld_q <= vld_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.func      <= fprti_pkg::func_t'(s_tdata[1:0]);
			item_s1.is_single <= s_tdata[2];
			item_s1.operand   <= s_tdata[66:3];
		end
		if (out_free) begin
			if (skid_vld_q) begin
				out_q <= skid_q;
				if (vld_s1)
					skid_q <= res_comb;
			end else if (vld_s1) begin
				out_q <= res_comb;
			end
		end else if (!skid_vld_q && vld_s1) begin
			skid_q <= res_comb;
		end
	end
endmodule
`default_nettype wire

// ===== dv/fp_round_to_integral_top_tb.sv =====
`timescale 1ns / 1ps
module fp_round_to_integral_top_tb;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [71:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [63:0] m_tdata;

	fp_round_to_integral_top dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	always #5 clk = ~clk;

	logic [71:0] pending_items[$];
	logic [63:0] expected_results[$];
	int          n_errors = 0;
	int          n_checked = 0;
	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;
	bit          hold_sender = 1'b0;

	// Integral value of one operand, generic over the two formats.
	function automatic logic [63:0] round_integral(fprti_pkg::func_t fn, logic [63:0] bits,
		int unsigned mb, int unsigned eb);
		logic [63:0] sign_bit, emax, bias, ef, neg, mag, unit, mask, frac, t;
		bit up;
		sign_bit = 64'd1 << (mb + eb);
		emax = (64'd1 << eb) - 1;
		bias = emax >> 1;
		ef = (bits >> mb) & emax;
		neg = bits & sign_bit;
		mag = bits & (sign_bit - 1);
		if (ef == emax) return bits;
		if (ef < bias) begin
			if (mag == 0) return bits;
			case (fn)
				fprti_pkg::FN_FLOOR: up = (neg != 0);
				fprti_pkg::FN_CEIL:  up = (neg == 0);
				fprti_pkg::FN_ROUND: up = (ef == bias - 1);
				default:             up = 1'b0;
			endcase
			return up ? (neg | (bias << mb)) : neg;
		end
		if (ef - bias >= mb) return bits;
		unit = 64'd1 << (mb - (ef - bias));
		mask = unit - 1;
		frac = bits & mask;
		if (frac == 0) return bits;
		t = bits & ~mask;
		case (fn)
			fprti_pkg::FN_FLOOR: up = (neg != 0);
			fprti_pkg::FN_CEIL:  up = (neg == 0);
			fprti_pkg::FN_ROUND: up = (frac >= (unit >> 1));
			default:             up = 1'b0;
		endcase
		return up ? t + unit : t;
	endfunction

	function automatic logic [63:0] predict_result(logic [71:0] d);
		fprti_pkg::func_t fn;
		fn = fprti_pkg::func_t'(d[1:0]);
		if (d[2])
			return {32'd0, round_integral(fn, {32'd0, d[34:3]}, fprti_pkg::SGL_MBITS,
				fprti_pkg::SGL_EBITS) & 64'hffff_ffff};
		return round_integral(fn, d[66:3], fprti_pkg::DBL_MBITS, fprti_pkg::DBL_EBITS);
	endfunction

	task automatic report_mismatch(logic [63:0] got, logic [63:0] want);
		$display("mismatch: result %h, expected %h", got, want);
		n_errors++;
	endtask

	task automatic push_item(fprti_pkg::func_t fn, bit sgl, logic [63:0] op);
		pending_items.push_back({5'd0, op, sgl, fn});
	endtask

	// Random operand: exponents biased around the binary point so all cases hit.
	function automatic logic [63:0] rand_operand(bit sgl);
		logic [63:0] op;
		int unsigned sel;
		op = {$urandom, $urandom};
		sel = $urandom_range(0, 9);
		if (sgl) begin
			case (sel)
				0, 1, 2, 3, 4: op[30:23] = 8'(127 + $urandom_range(0, 24) - 2);
				5: op[30:23] = 8'hff;
				6: op[30:23] = 8'($urandom_range(0, 126));
				7: op[22:0] = op[22:0] & ~(23'h7fffff >> $urandom_range(0, 23));
				default: ;
			endcase
		end else begin
			case (sel)
				0, 1, 2, 3, 4: op[62:52] = 11'(1023 + $urandom_range(0, 53) - 2);
				5: op[62:52] = 11'h7ff;
				6: op[62:52] = 11'($urandom_range(0, 1022));
				7: op[51:0] = op[51:0] & ~(52'hf_ffff_ffff_ffff >> $urandom_range(0, 52));
				default: ;
			endcase
		end
		return op;
	endfunction

	// Driver: moves queued items onto the slave side.
	always @(posedge clk) begin
		if (arst_n) begin
			if (!s_tvalid || s_tready) begin
				if (pending_items.size() != 0 && !hold_sender
					&& $urandom_range(0, 99) >= send_idle_pct) begin
					s_tdata <= pending_items[0];
					s_tvalid <= 1'b1;
					expected_results.push_back(predict_result(pending_items[0]));
					void'(pending_items.pop_front());
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks each accepted result against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (expected_results.size() == 0) begin
					$display("unexpected result %h", m_tdata);
					n_errors++;
				end else begin
					if (m_tdata !== expected_results[0])
						report_mismatch(m_tdata, expected_results[0]);
					void'(expected_results.pop_front());
					n_checked++;
				end
			end
			m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	initial begin
		#2_000_000;
		$display("FAIL fp_round_to_integral_top");
		$finish;
	end

	initial begin
		int ph;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		// directed: zeros, halves, subnormals, NaN/inf, big values, both formats
		for (int f = 0; f < 4; f++) begin
			push_item(fprti_pkg::func_t'(f), 0, 64'hbfe0_0000_0000_0000);  // -0.5
			push_item(fprti_pkg::func_t'(f), 0, 64'h4004_0000_0000_0000);  // 2.5
			push_item(fprti_pkg::func_t'(f), 0, 64'h8000_0000_0000_0001);  // -min subnormal
			push_item(fprti_pkg::func_t'(f), 1, 64'hffff_ffff_bf99_999a);  // -1.2f, junk above
			push_item(fprti_pkg::func_t'(f), 1, 64'h0000_0000_3f00_0000);  // 0.5f
		end
		push_item(fprti_pkg::FN_ROUND, 0, 64'h8000_0000_0000_0000);
		push_item(fprti_pkg::FN_CEIL, 0, 64'h7ff4_0000_0000_0001);      // signaling NaN
		push_item(fprti_pkg::FN_FLOOR, 0, 64'hfff0_0000_0000_0000);
		push_item(fprti_pkg::FN_ROUND, 0, 64'h4330_0000_0000_0001);     // 2^52 + 1
		push_item(fprti_pkg::FN_CEIL, 0, 64'h432f_ffff_ffff_ffff);      // carry into exponent
		push_item(fprti_pkg::FN_FLOOR, 1, 64'h0000_0000_ff80_0001);
		push_item(fprti_pkg::FN_ROUND, 1, 64'h0000_0000_4b7f_ffff);
		for (ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
				default: begin send_idle_pct = 7; recv_stall_pct = 7; end
			endcase
			for (int i = 0; i < 410; i++) begin
				bit sgl;
				sgl = 1'($urandom_range(0, 1));
				push_item(fprti_pkg::func_t'($urandom_range(0, 3)), sgl, rand_operand(sgl));
			end
			while (pending_items.size() != 0) @(posedge clk);
			if (ph == 1) begin
				// pause the sender until the pipeline drains
				hold_sender = 1'b1;
				while (expected_results.size() != 0 || s_tvalid) @(posedge clk);
				hold_sender = 1'b0;
			end
		end
		while (expected_results.size() != 0 || s_tvalid) @(posedge clk);
		repeat (10) @(posedge clk);
		$display("checked %0d results: all four operations, both precisions,", n_checked);
		$display("specials, sub-one magnitudes and carries, under varied backpressure");
		if (n_errors == 0)
			$display("PASS fp_round_to_integral_top");
		else
			$display("FAIL fp_round_to_integral_top");
		$finish;
	end
endmodule

// ===== fp_round_to_integral_top.f =====
hdl/fprti_pkg.sv
hdl/fprti_core.sv
hdl/fp_round_to_integral_top.sv
dv/fp_round_to_integral_top_tb.sv
